// ===== rtl/core/lsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbc_pkg: shared types and codes of the lidar sector brake check
// Operation codes, register indexes, reason codes and the result record.
// ----------------------------------------------------------------------------
package lsbc_pkg;

	// Fixed geometry: eight 45-degree sectors.
	localparam int SECTOR_COUNT = 8;
	localparam int SECTOR_BITS  = 3;

	// Operation carried by an input transaction.
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_EVAL   = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_BRAKE_ENABLE   = 3'd0;
	localparam logic [2:0] REG_MAX_AGE_TICKS  = 3'd1;
	localparam logic [2:0] REG_VALID_MIN_MM   = 3'd2;
	localparam logic [2:0] REG_VALID_MAX_MM   = 3'd3;
	localparam logic [2:0] REG_ANGLE_SETUP    = 3'd4;
	localparam logic [2:0] REG_SECTOR_ENABLE  = 3'd5;
	localparam logic [2:0] REG_THRESHOLDS_LOW = 3'd6;
	localparam logic [2:0] REG_THRESHOLDS_HI  = 3'd7;

	// Reason reported with an evaluation.
	localparam logic [2:0] REASON_CLEAR    = 3'd0;
	localparam logic [2:0] REASON_DISABLED = 3'd1;
	localparam logic [2:0] REASON_WAITING  = 3'd2;
	localparam logic [2:0] REASON_STALE    = 3'd3;
	localparam logic [2:0] REASON_BLOCKED  = 3'd4;

	// Saturation value of the scan age.
	localparam logic [15:0] AGE_MAX = 16'hFFFF;

	// One evaluation result.
	typedef struct packed {
		logic [15:0]            blocking_range_mm;
		logic [SECTOR_BITS-1:0] hit_sector;
		logic [2:0]             reason_code;
		logic                   brake_req;
	} brake_res_t;

endpackage

// ===== rtl/core/lidar_sector_brake_check.sv =====
// ----------------------------------------------------------------------------
// lidar_sector_brake_check: sector brake check over a lidar scan
// Tracks per-sector nearest ranges of each scan and answers brake requests.
// ----------------------------------------------------------------------------
// The block takes one transaction in every cycle unless its input side stalls.
// An accepted item is held in a single input stage, where a range sample
// updates the sector minima, a tick ages the scan and an evaluate request is
// resolved by an eight-way priority check, whose result is registered as the
// request leaves the input stage. The input side stalls only while an evaluate
// request waits in the input stage and the output register still holds a
// result not taken. Samples and ticks produce no result transaction.
module lidar_sector_brake_check
	import lsbc_pkg::*;
#(
	parameter int RANGE_BITS = 16,
	parameter int ANGLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] range_mm
	input  logic [2:0]  s_axis_tuser,  // [1:0] op, [2] range_finite
	input  logic        s_axis_tlast,  // last_sample
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] brake request, [3:1] reason_code, [6:4] blocking sector index,
	// [22:7] blocking_range_mm, [23] zero
	output logic [23:0] m_axis_tdata
);

	localparam int CMP_BITS = (RANGE_BITS > 16) ? RANGE_BITS : 16;
	localparam logic [RANGE_BITS-1:0] RANGE_ALL = {RANGE_BITS{1'b1}};
	localparam logic [ANGLE_BITS-1:0] HALF_SECTOR = {4'b0001, {(ANGLE_BITS-4){1'b0}}};

	// Configuration registers
	logic                  brake_enable_q;
	logic [15:0]           max_age_ticks_q;
	logic [15:0]           valid_min_mm_q;
	logic [15:0]           valid_max_mm_q;
	logic [ANGLE_BITS-1:0] start_angle_q;
	logic [ANGLE_BITS-1:0] angle_step_q;
	logic [7:0]            sector_enable_q;
	logic [15:0]           threshold_q [SECTOR_COUNT];

	// Scan state
	logic [RANGE_BITS-1:0] working_nearest_q   [SECTOR_COUNT];
	logic                  working_seen_q      [SECTOR_COUNT];
	logic [RANGE_BITS-1:0] committed_nearest_q [SECTOR_COUNT];
	logic                  committed_seen_q    [SECTOR_COUNT];
	logic                  scan_present_q;
	logic [15:0]           scan_age_q;
	logic [ANGLE_BITS-1:0] angle_acc_q;
	logic                  scan_in_progress_q;

	// Input stage
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] range_s1;
	logic        finite_s1;
	logic        last_s1;

	// Output register
	logic       out_valid_q;
	brake_res_t res_q;

	// Stage control
	logic s1_advance;
	logic s1_fire;
	logic s1_eval;
	logic commit;

	// Sample datapath
	logic                   scan_start;
	logic [ANGLE_BITS-1:0]  angle_cur;
	logic [ANGLE_BITS-1:0]  angle_rot;
	logic [SECTOR_BITS-1:0] sample_sector;
	logic [CMP_BITS-1:0]    range_ext;
	logic [RANGE_BITS-1:0]  range_sat;
	logic                   sample_ok;
	logic [RANGE_BITS-1:0]  nearest_next [SECTOR_COUNT];
	logic                   seen_next    [SECTOR_COUNT];

	// Evaluation datapath
	brake_res_t eval_res;

	// Handshake: the input stage drains unless an evaluate result cannot be stored.
	assign s1_eval       = valid_s1 && (op_s1 == OP_EVAL);
	assign s1_advance    = !s1_eval || !out_valid_q || m_axis_tready;
	assign s1_fire       = valid_s1 && s1_advance;
	assign s_axis_tready = !valid_s1 || s1_advance;
	assign commit        = s1_fire && (op_s1 == OP_SAMPLE) && last_s1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brake_enable_q  <= 1'b0;
			max_age_ticks_q <= 16'd100;
			valid_min_mm_q  <= 16'd100;
			valid_max_mm_q  <= 16'd30000;
			start_angle_q   <= '0;
			angle_step_q    <= '0;
			sector_enable_q <= 8'hFF;
			for (int k = 0; k < SECTOR_COUNT; k++) begin
				threshold_q[k] <= '0;
			end
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_BRAKE_ENABLE:  brake_enable_q  <= cfg_data[0];
				REG_MAX_AGE_TICKS: max_age_ticks_q <= cfg_data[15:0];
				REG_VALID_MIN_MM:  valid_min_mm_q  <= cfg_data[15:0];
				REG_VALID_MAX_MM:  valid_max_mm_q  <= cfg_data[15:0];
				REG_ANGLE_SETUP: begin
					start_angle_q <= cfg_data[32 +: ANGLE_BITS];
					angle_step_q  <= cfg_data[ANGLE_BITS-1:0];
				end
				REG_SECTOR_ENABLE: sector_enable_q <= cfg_data[7:0];
				REG_THRESHOLDS_LOW: begin
					for (int k = 0; k < 4; k++) begin
						threshold_q[k] <= cfg_data[16*k +: 16];
					end
				end
				REG_THRESHOLDS_HI: begin
					for (int k = 0; k < 4; k++) begin
						threshold_q[k+4] <= cfg_data[16*k +: 16];
					end
				end
				default: ;
			endcase
		end
	end

	// Input stage: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input stage: payload, loaded on each accepted transaction.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1     <= s_axis_tuser[1:0];
			finite_s1 <= s_axis_tuser[2];
			range_s1  <= s_axis_tdata;
			last_s1   <= s_axis_tlast;
		end
	end

	// Sample path: pick the sector from the rotated angle and fold in the range.
	always_comb begin
		scan_start    = !scan_in_progress_q;
		angle_cur     = scan_start ? start_angle_q : angle_acc_q;
		angle_rot     = angle_cur + HALF_SECTOR;
		sample_sector = angle_rot[ANGLE_BITS-1 -: SECTOR_BITS];
		range_ext     = CMP_BITS'(range_s1);
		range_sat     = (range_ext > CMP_BITS'(RANGE_ALL)) ? RANGE_ALL
			: RANGE_BITS'(range_ext);
		sample_ok     = finite_s1
			&& (CMP_BITS'(range_sat) >= CMP_BITS'(valid_min_mm_q))
			&& (CMP_BITS'(range_sat) <= CMP_BITS'(valid_max_mm_q));
		for (int k = 0; k < SECTOR_COUNT; k++) begin
			nearest_next[k] = scan_start ? RANGE_ALL : working_nearest_q[k];
			seen_next[k]    = scan_start ? 1'b0 : working_seen_q[k];
			if (sample_ok && (sample_sector == SECTOR_BITS'(k))) begin
				seen_next[k] = 1'b1;
				if (range_sat < nearest_next[k]) begin
					nearest_next[k] = range_sat;
				end
			end
		end
	end

	// Scan state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SECTOR_COUNT; k++) begin
				working_nearest_q[k]   <= RANGE_ALL;
				working_seen_q[k]      <= 1'b0;
				committed_nearest_q[k] <= RANGE_ALL;
				committed_seen_q[k]    <= 1'b0;
			end
			scan_present_q     <= 1'b0;
			scan_age_q         <= '0;
			angle_acc_q        <= '0;
			scan_in_progress_q <= 1'b0;
		end else if (s1_fire) begin
			if (op_s1 == OP_SAMPLE) begin
				for (int k = 0; k < SECTOR_COUNT; k++) begin
					working_nearest_q[k] <= nearest_next[k];
					working_seen_q[k]    <= seen_next[k];
				end
				angle_acc_q        <= angle_cur + angle_step_q;
				scan_in_progress_q <= !last_s1;
				if (last_s1) begin
					for (int k = 0; k < SECTOR_COUNT; k++) begin
						committed_nearest_q[k] <= nearest_next[k];
						committed_seen_q[k]    <= seen_next[k];
					end
					scan_present_q <= 1'b1;
					scan_age_q     <= '0;
				end
			end else if (op_s1 == OP_TICK) begin
				if (scan_age_q != AGE_MAX) begin
					scan_age_q <= scan_age_q + 16'd1;
				end
			end
		end
	end

	// Evaluation: global checks first, then the lowest enabled blocking sector.
	always_comb begin
		eval_res.brake_req         = 1'b0;
		eval_res.reason_code       = REASON_CLEAR;
		eval_res.hit_sector        = '0;
		eval_res.blocking_range_mm = 16'(RANGE_ALL);
		priority if (!brake_enable_q) begin
			eval_res.reason_code = REASON_DISABLED;
		end else if (!scan_present_q) begin
			eval_res.brake_req   = 1'b1;
			eval_res.reason_code = REASON_WAITING;
		end else if (scan_age_q > max_age_ticks_q) begin
			eval_res.brake_req   = 1'b1;
			eval_res.reason_code = REASON_STALE;
		end else begin
			for (int k = SECTOR_COUNT - 1; k >= 0; k--) begin
				if (sector_enable_q[k] && (!committed_seen_q[k]
					|| CMP_BITS'(committed_nearest_q[k]) < CMP_BITS'(threshold_q[k]))) begin
					eval_res.brake_req         = 1'b1;
					eval_res.reason_code       = REASON_BLOCKED;
					eval_res.hit_sector        = SECTOR_BITS'(k);
					eval_res.blocking_range_mm = 16'(committed_nearest_q[k]);
				end
			end
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_eval) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: result record.
	always_ff @(posedge clk) begin
		if (s1_fire && s1_eval) begin
			res_q <= eval_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, res_q};

`ifndef SYNTHESIS
	// A new result only follows an evaluate request leaving the input stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_fire && s1_eval))
		else $error("result raised without an evaluate request");

	// Once a scan has been committed it never goes away.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(scan_present_q))
		else $error("scan_present cleared after commit");

	// Committing a scan restarts its age, marks a scan present and ends the scan in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (scan_age_q == '0) && scan_present_q && !scan_in_progress_q)
		else $error("scan commit did not reset age and progress");

	// Braking follows the reason code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.brake_req ==
			((res_q.reason_code != REASON_CLEAR) && (res_q.reason_code != REASON_DISABLED))))
		else $error("brake request disagrees with reason_code");

	// Without a blocking sector the sector fields hold their defaults.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.reason_code != REASON_BLOCKED)) |->
			((res_q.hit_sector == '0)
			&& (res_q.blocking_range_mm == 16'(RANGE_ALL))))
		else $error("sector fields set without a blocking sector");
`endif

endmodule

// ===== dv/lidar_sector_brake_check_tb.sv =====
// ----------------------------------------------------------------------------
// lidar_sector_brake_check_tb: self-checking bench of the sector brake check
// Drives samples, ticks and evaluate requests with random idling on both
// streams, predicts every evaluation result and compares each result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lidar_sector_brake_check_tb;
	import lsbc_pkg::*;

	// Operation code that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Predicts the block's evaluation results and holds those still due.
	class sector_brake_predictor;
		// Register copies.
		bit          brake_on;
		logic [15:0] age_limit;
		logic [15:0] window_lo;
		logic [15:0] window_hi;
		logic [63:0] angle_cfg;
		logic [7:0]  sector_mask;
		logic [63:0] thr_low_word;
		logic [63:0] thr_high_word;
		// Scan state.
		logic [15:0] work_nearest [SECTOR_COUNT];
		bit          work_seen [SECTOR_COUNT];
		logic [15:0] kept_nearest [SECTOR_COUNT];
		bit          kept_seen [SECTOR_COUNT];
		bit          scan_held;
		logic [15:0] scan_age;
		logic [31:0] angle_acc;
		bit          mid_scan;
		brake_res_t  due_verdicts [$];
		int          failures;

		function new();
			brake_on      = 1'b0;
			age_limit     = 16'd100;
			window_lo     = 16'd100;
			window_hi     = 16'd30000;
			angle_cfg     = '0;
			sector_mask   = 8'hFF;
			thr_low_word  = '0;
			thr_high_word = '0;
			for (int k = 0; k < SECTOR_COUNT; k++) begin
				work_nearest[k] = 16'hFFFF;
				work_seen[k]    = 1'b0;
				kept_nearest[k] = 16'hFFFF;
				kept_seen[k]    = 1'b0;
			end
			scan_held = 1'b0;
			scan_age  = '0;
			angle_acc = '0;
			mid_scan  = 1'b0;
			failures  = 0;
		endfunction

		function void load_register(logic [2:0] idx, logic [63:0] value);
			case (idx)
				REG_BRAKE_ENABLE:   brake_on      = value[0];
				REG_MAX_AGE_TICKS:  age_limit     = value[15:0];
				REG_VALID_MIN_MM:   window_lo     = value[15:0];
				REG_VALID_MAX_MM:   window_hi     = value[15:0];
				REG_ANGLE_SETUP:    angle_cfg     = value;
				REG_SECTOR_ENABLE:  sector_mask   = value[7:0];
				REG_THRESHOLDS_LOW: thr_low_word  = value;
				REG_THRESHOLDS_HI:  thr_high_word = value;
				default: ;
			endcase
		endfunction

		function logic [15:0] threshold(int k);
			if (k < 4)
				return thr_low_word[16*k +: 16];
			return thr_high_word[16*(k-4) +: 16];
		endfunction

		// Applies one accepted input transaction to the predicted state.
		function void note_transaction(logic [1:0] op, logic [15:0] rng, bit finite,
				bit last);
			logic [31:0] rotated;
			int          sec;
			brake_res_t  verdict;
			case (op)
				OP_SAMPLE: begin
					if (!mid_scan) begin
						for (int k = 0; k < SECTOR_COUNT; k++) begin
							work_nearest[k] = 16'hFFFF;
							work_seen[k]    = 1'b0;
						end
						angle_acc = angle_cfg[63:32];
						mid_scan  = 1'b1;
					end
					if (finite && rng >= window_lo && rng <= window_hi) begin
						// Rotate by a sixteenth of a turn so sector 0 straddles front.
						rotated = angle_acc + 32'h1000_0000;
						sec = rotated[31:29];
						work_seen[sec] = 1'b1;
						if (rng < work_nearest[sec])
							work_nearest[sec] = rng;
					end
					angle_acc = angle_acc + angle_cfg[31:0];
					if (last) begin
						kept_nearest = work_nearest;
						kept_seen    = work_seen;
						scan_held    = 1'b1;
						scan_age     = '0;
						mid_scan     = 1'b0;
					end
				end
				OP_TICK: begin
					if (scan_age != AGE_MAX)
						scan_age = scan_age + 16'd1;
				end
				OP_EVAL: begin
					verdict = '0;
					verdict.blocking_range_mm = 16'hFFFF;
					verdict.reason_code       = REASON_CLEAR;
					if (!brake_on) begin
						verdict.reason_code = REASON_DISABLED;
					end else if (!scan_held) begin
						verdict.brake_req   = 1'b1;
						verdict.reason_code = REASON_WAITING;
					end else if (scan_age > age_limit) begin
						verdict.brake_req   = 1'b1;
						verdict.reason_code = REASON_STALE;
					end else begin
						// Lowest enabled sector that is unseen or too near wins.
						for (int k = 0; k < SECTOR_COUNT; k++) begin
							if (sector_mask[k] && (!kept_seen[k] ||
									kept_nearest[k] < threshold(k))) begin
								verdict.brake_req         = 1'b1;
								verdict.reason_code       = REASON_BLOCKED;
								verdict.hit_sector        = k[SECTOR_BITS-1:0];
								verdict.blocking_range_mm = kept_nearest[k];
								break;
							end
						end
					end
					due_verdicts.push_back(verdict);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			failures++;
		endtask

		// Compares one result transaction with the oldest due verdict.
		task check_verdict(logic [23:0] word);
			brake_res_t want;
			if (due_verdicts.size() == 0) begin
				report($sformatf("result 0x%06h with none due", word));
				return;
			end
			want = due_verdicts.pop_front();
			if (word[0] !== want.brake_req)
				report($sformatf("brake request %b, predicted %b", word[0],
					want.brake_req));
			if (word[3:1] !== want.reason_code)
				report($sformatf("reason_code %0d, predicted %0d", word[3:1],
					want.reason_code));
			if (word[6:4] !== want.hit_sector)
				report($sformatf("blocking sector index %0d, predicted %0d", word[6:4],
					want.hit_sector));
			if (word[22:7] !== want.blocking_range_mm)
				report($sformatf("blocking_range_mm %0d, predicted %0d", word[22:7],
					want.blocking_range_mm));
			if (word[23] !== 1'b0)
				report("padding bit of the result is not zero");
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // [15:0] range_mm
	logic [2:0]  s_axis_tuser;  // [1:0] op, [2] range_finite
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // [0] brake, [3:1] reason, [6:4] sector, [22:7] range

	sector_brake_predictor sb = new();

	// No idling on either side while this is set.
	bit          steady = 1'b0;
	logic [15:0] win_lo;
	logic [15:0] win_hi;
	int          scan_len;

	lidar_sector_brake_check DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side stalls at random.
	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 27);
	end

	// Every accepted result is checked.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_verdict(m_axis_tdata);
	end

	// Drives one input transaction; starts and ends at a falling edge.
	task automatic send_item(logic [1:0] op, logic [15:0] rng, bit finite, bit last);
		while (!steady && $urandom_range(99) < 27) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rng;
		s_axis_tuser  <= {finite, op};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_transaction(op, rng, finite, last);
		@(negedge clk);
	endtask

	// Tick, evaluate or unused operation with random unused fields.
	task automatic send_op(logic [1:0] op);
		send_item(op, 16'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// Waits until the block has drained before a register write.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.due_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.load_register(idx, value);
		if (idx == REG_VALID_MIN_MM)
			win_lo = value[15:0];
		if (idx == REG_VALID_MAX_MM)
			win_hi = value[15:0];
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// One scan sample: mostly inside the acceptance window when there is one.
	task automatic send_scan_sample(bit last);
		logic [15:0] rng;
		if (win_lo <= win_hi && $urandom_range(99) < 85)
			rng = 16'($urandom_range(win_hi, win_lo));
		else
			rng = 16'($urandom);
		send_item(OP_SAMPLE, rng, $urandom_range(99) < 90, last);
	endtask

	// Writes every register with a setting chosen for the phase.
	task automatic configure_phase(int p);
		logic [15:0] lo;
		logic [15:0] hi;
		logic [31:0] step;
		logic [63:0] thr [2];
		int          sh;
		settle();
		write_reg(REG_BRAKE_ENABLE, (p == 2) ? 64'd0 : 64'($urandom_range(99) < 92));
		case (p % 4)
			0: write_reg(REG_MAX_AGE_TICKS, 64'd0);
			1: write_reg(REG_MAX_AGE_TICKS, 64'hFFFF);
			2: write_reg(REG_MAX_AGE_TICKS, 64'($urandom_range(40)));
			default: write_reg(REG_MAX_AGE_TICKS, 64'd100);
		endcase
		case (p % 5)
			0: begin lo = 16'd100; hi = 16'd30000; end
			1: begin lo = 16'd0; hi = 16'hFFFF; end
			2: begin
				// Empty window: nothing is accepted.
				lo = 16'($urandom_range(65535, 20000));
				hi = 16'($urandom_range(lo - 1, 0));
			end
			3: begin
				lo = 16'($urandom_range(20000));
				hi = lo + 16'($urandom_range(5000));
			end
			default: begin lo = 16'($urandom); hi = 16'($urandom); end
		endcase
		write_reg(REG_VALID_MIN_MM, 64'(lo));
		write_reg(REG_VALID_MAX_MM, 64'(hi));
		sh = $urandom_range(2);
		scan_len = 8 << sh;
		step = (32'h1 << (29 - sh)) + 32'($urandom_range(4095));
		if (p == 5) begin
			scan_len = 16;
			write_reg(REG_ANGLE_SETUP, '1);
		end else if (p == 7) begin
			write_reg(REG_ANGLE_SETUP, '0);
		end else begin
			write_reg(REG_ANGLE_SETUP, {32'($urandom), step});
		end
		case (p % 3)
			0: write_reg(REG_SECTOR_ENABLE, 64'hFF);
			1: write_reg(REG_SECTOR_ENABLE, (p == 4) ? 64'h00 : 64'($urandom_range(255)));
			default: write_reg(REG_SECTOR_ENABLE, 64'($urandom_range(255)));
		endcase
		for (int w = 0; w < 2; w++) begin
			case ((p + w) % 4)
				0: thr[w] = '0;
				1: thr[w] = (p == 1) ? '1 : {$urandom, $urandom};
				default: begin
					for (int k = 0; k < 4; k++)
						thr[w][16*k +: 16] = 16'($urandom_range(3000));
				end
			endcase
		end
		write_reg(REG_THRESHOLDS_LOW, thr[0]);
		write_reg(REG_THRESHOLDS_HI, thr[1]);
	endtask

	// Mostly whole scans with ticks and evaluations mixed in, the rest noise.
	task automatic run_phase(int budget);
		int  sent;
		int  len;
		int  burst;
		bit  whole;
		logic [1:0] op;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 80) begin
				whole = $urandom_range(99) < 88;
				len = whole ? scan_len : $urandom_range(scan_len, 1);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(99) < 6) begin
						send_op(OP_TICK);
						sent++;
					end
					if ($urandom_range(99) < 5) begin
						send_op(OP_EVAL);
						sent++;
					end
					send_scan_sample(whole && i == len - 1);
					sent++;
				end
				if ($urandom_range(99) < 30) begin
					burst = $urandom_range(45);
					repeat (burst) send_op(OP_TICK);
					sent += burst;
				end
				if ($urandom_range(99) < 75) begin
					send_op(OP_EVAL);
					sent++;
				end
			end else begin
				op = 2'($urandom);
				if (op == OP_SAMPLE)
					send_item(op, 16'($urandom), 1'($urandom), $urandom_range(9) == 0);
				else
					send_op(op);
				if (op != OP_UNUSED)
					sent++;
			end
		end
	endtask

	// Directed samples: one full turn in sixteenth steps, two per sector.
	logic [15:0] turn_range [16] = '{16'd0, 16'hFFFF, 16'd99, 16'd100, 16'd30000,
		16'd30001, 16'd500, 16'd200, 16'hAAAA, 16'h5555, 16'd1000, 16'd2000,
		16'd3000, 16'd100, 16'd4000, 16'd4100};
	bit          turn_finite [16] = '{1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 0, 1, 1, 1};

	// Main sequence.
	initial begin
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_index     = REG_BRAKE_ENABLE;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tlast  = 1'b0;
		win_lo        = 16'd100;
		win_hi        = 16'd30000;
		scan_len      = 16;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: disabled, ignored code, waiting for a scan.
		send_op(OP_EVAL);
		send_op(OP_UNUSED);
		settle();
		write_reg(REG_BRAKE_ENABLE, 64'd1);
		send_op(OP_EVAL);
		send_op(OP_TICK);
		settle();
		write_reg(REG_ANGLE_SETUP, {32'hF000_0000, 32'h1000_0000});
		for (int i = 0; i < 16; i++)
			send_item(OP_SAMPLE, turn_range[i], turn_finite[i], i == 15);
		// Front sector unseen, then clear with it masked off.
		send_op(OP_EVAL);
		settle();
		write_reg(REG_SECTOR_ENABLE, 64'hFE);
		send_op(OP_EVAL);
		// A minimum equal to its threshold passes, one below it blocks.
		settle();
		write_reg(REG_THRESHOLDS_LOW, {16'd0, 16'd30001, 16'd100, 16'd0});
		send_op(OP_EVAL);
		settle();
		write_reg(REG_MAX_AGE_TICKS, 64'd0);
		send_op(OP_TICK);
		send_op(OP_EVAL);

		// An age equal to the limit passes, one beyond it is stale.
		settle();
		write_reg(REG_MAX_AGE_TICKS, 64'd41);
		steady = 1'b1;
		repeat (40) send_op(OP_TICK);
		send_op(OP_EVAL);
		settle();
		write_reg(REG_MAX_AGE_TICKS, 64'd40);
		send_op(OP_EVAL);
		steady = 1'b0;

		// Random phases over a spread of settings.
		for (int p = 0; p < 12; p++) begin
			configure_phase(p);
			steady = (p == 3);
			run_phase(145);
			steady = 1'b0;
		end

		// Drain and finish.
		s_axis_tvalid <= 1'b0;
		while (sb.due_verdicts.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.failures == 0 && sb.due_verdicts.size() == 0)
			$display("lidar_sector_brake_check_tb: PASS");
		else
			$display("lidar_sector_brake_check_tb: FAIL");
		$finish;
	end

	// Watchdog.
	initial begin
		#20_000_000;
		$display("lidar_sector_brake_check_tb: FAIL");
		$finish;
	end

endmodule
